// ===== rtl/assert_macros.svh =====
// Assertion helper macros shared by the RTL.
// No dependencies; the user must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication check, muted while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, expr, msg) \
    `ASSERT_CLK(label, !(expr), msg)

`endif

// ===== rtl/mtk_pkg.sv =====
// Shared types, constants and the letter glyph table for the Morse keyer.
// No dependencies.
package mtk_pkg;

    localparam int unsigned CODE_BITS   = 16;
    localparam int unsigned HOLD_W      = 14;
    localparam int unsigned NUM_LETTERS = 26;
    localparam int unsigned MAX_SYMS    = 4;
    localparam int unsigned CMD_DEPTH   = 2;

    typedef enum logic [2:0] {
        SYM_NONE  = 3'd0,
        SYM_DOT   = 3'd1,
        SYM_DASH  = 3'd2,
        SYM_SPACE = 3'd3,
        SYM_NL    = 3'd4
    } t_sym;

    typedef enum logic [1:0] {
        CLS_NONE   = 2'd0,
        CLS_LETTER = 2'd1,
        CLS_SPACE  = 2'd2
    } t_cls;

    typedef enum logic [1:0] {
        REG_DOT        = 2'd0,
        REG_DASH       = 2'd1,
        REG_LETTER_GAP = 2'd2,
        REG_WORD_GAP   = 2'd3
    } t_reg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WSP0,
        ST_WSP1,
        ST_WSP2,
        ST_LGAP,
        ST_LSPC,
        ST_MARK,
        ST_SOFF,
        ST_NL
    } t_seq_state;

    // Symbols of one letter: count and a dash flag per slot (slot 0 first).
    typedef struct packed {
        logic [2:0] nsym;
        logic [3:0] dash;
    } t_glyph;

    typedef t_glyph [NUM_LETTERS-1:0] t_glyph_tab;

    // Command passed from the front end to the sequencer.
    typedef struct packed {
        logic       word_gap;
        logic       letter_gap;
        logic [2:0] nsym;
        logic [3:0] dash;
        logic       eot;
    } t_cmd;

    typedef struct packed {
        logic [HOLD_W-1:0] dot;
        logic [HOLD_W-1:0] dash;
        logic [HOLD_W-1:0] letter_gap;
        logic [HOLD_W-1:0] word_gap;
    } t_timing;

    localparam logic [15:0] LETTER_PAT [NUM_LETTERS] = '{
        16'hB800, 16'hEA80, 16'hEBA0, 16'hEA00, 16'h8000, 16'hAE80, 16'hEE80,
        16'hAA00, 16'hA000, 16'hBBB8, 16'hEB80, 16'hBA80, 16'hEE00, 16'hE800,
        16'hEEE0, 16'hBBA0, 16'hEEB8, 16'hBA00, 16'hA800, 16'hE000, 16'hAE00,
        16'hAB80, 16'hBB80, 16'hEAE0, 16'hEBB8, 16'hEEA0
    };

    // Walk each on/off pattern MSB first. A lone 1 then 0 is a dot, three 1s
    // then 0 a dash; other run lengths keep counting past the 0.
    // Evaluated at elaboration only.
    function automatic t_glyph_tab build_glyph_tab(int unsigned code_bits);
        t_glyph_tab  tab;
        int unsigned run;
        int unsigned cnt;
        tab = '0;
        for (int unsigned l = 0; l < NUM_LETTERS; l++) begin
            run = 0;
            cnt = 0;
            for (int unsigned i = 0; i < 16; i++) begin
                if (i < code_bits) begin
                    if (LETTER_PAT[l][15-i]) begin
                        run = run + 1;
                    end else if (run == 3) begin
                        if (cnt < MAX_SYMS) begin
                            tab[l].dash[cnt[1:0]] = 1'b1;
                        end
                        cnt = cnt + 1;
                        run = 0;
                    end else if (run == 1) begin
                        cnt = cnt + 1;
                        run = 0;
                    end
                end
            end
            tab[l].nsym = cnt[2:0];
        end
        return tab;
    endfunction

endpackage

// ===== rtl/mtk_front.sv =====
// Front end: takes text bytes, classifies them, tracks spacing state and
// queues keying commands. Depends on mtk_pkg.
module mtk_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic          i_room,
    input  logic [7:0]    i_char_code,
    input  logic          i_end_of_text,
    output logic          o_push,
    output mtk_pkg::t_cmd o_cmd
);
    import mtk_pkg::*;

    localparam t_glyph_tab GLYPHS = build_glyph_tab(CODE_BITS);

    t_cls       r_prev_class, n_prev_class;
    logic       r_first_word, n_first_word;
    logic [4:0] low;
    logic [4:0] idx;
    logic       is_letter;
    logic       is_space;
    logic       accept;
    t_glyph     glyph;

    // Upper or lower case ASCII letter: 0x41..0x5A or 0x61..0x7A.
    assign low       = i_char_code[4:0];
    assign idx       = low - 5'd1;
    assign is_letter = (i_char_code[7:6] == 2'b01) && (low != 5'd0) && (low <= 5'd26);
    assign is_space  = (i_char_code == 8'h20);
    assign glyph     = is_letter ? GLYPHS[idx] : '0;
    assign accept    = i_valid && i_room;

    always_comb begin
        o_cmd.word_gap   = is_letter && !r_first_word && (r_prev_class == CLS_SPACE);
        o_cmd.letter_gap = is_letter && (r_prev_class == CLS_LETTER);
        o_cmd.nsym       = glyph.nsym;
        o_cmd.dash       = glyph.dash;
        o_cmd.eot        = i_end_of_text;
    end

    // Bytes that cause nothing are dropped here.
    assign o_push = accept && (is_letter || i_end_of_text);

    always_comb begin
        n_prev_class = r_prev_class;
        n_first_word = r_first_word;
        if (accept) begin
            if (is_letter) begin
                n_prev_class = CLS_LETTER;
                n_first_word = 1'b0;
            end else if (is_space) begin
                n_prev_class = CLS_SPACE;
            end
            if (i_end_of_text) begin
                n_prev_class = CLS_NONE;
                n_first_word = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_class <= CLS_NONE;
            r_first_word <= 1'b1;
        end else begin
            r_prev_class <= n_prev_class;
            r_first_word <= n_first_word;
        end
    end

endmodule

// ===== rtl/mtk_cmd_fifo.sv =====
// Two-entry command queue between front end and sequencer.
// Depends on mtk_pkg.
module mtk_cmd_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  mtk_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output mtk_pkg::t_cmd o_cmd,
    output logic          o_full,
    output logic          o_empty
);
    import mtk_pkg::*;

    localparam int unsigned PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(CMD_DEPTH + 1);

    t_cmd             r_mem [CMD_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == CNT_W'(CMD_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/mtk_back.sv =====
// Back end: sequencer that expands one queued command into keying events,
// one per cycle unless the output is stalled, through a registered output slot. Depends on mtk_pkg.
module mtk_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  mtk_pkg::t_cmd                  i_cmd,
    output logic                           o_pop,
    input  mtk_pkg::t_timing               i_timing,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output mtk_pkg::t_sym                  o_echo_symbol,
    output logic                           o_led_on,
    output logic [mtk_pkg::HOLD_W-1:0]     o_hold_ms,
    output logic                           o_last_result
);
    import mtk_pkg::*;

    t_seq_state        r_state, n_state;
    t_cmd              r_cmd;
    logic [1:0]        r_idx, n_idx;
    logic              r_out_valid;
    t_sym              r_sym;
    logic              r_led;
    logic [HOLD_W-1:0] r_hold;
    logic              r_last;

    logic              adv;
    logic              more_sym;
    t_seq_state        first_state;
    t_seq_state        body_state;
    t_seq_state        tail_state;
    logic              emit;
    t_sym              sym;
    logic              led;
    logic [HOLD_W-1:0] hold;

    assign adv      = !r_out_valid || i_out_ready;
    assign more_sym = ({1'b0, r_idx} + 3'd1) < r_cmd.nsym;
    assign o_pop    = (r_state == ST_IDLE) && !i_empty;

    // Entry point for a freshly popped command.
    always_comb begin
        if (i_cmd.word_gap) begin
            first_state = ST_WSP0;
        end else if (i_cmd.letter_gap) begin
            first_state = ST_LGAP;
        end else if (i_cmd.nsym != 3'd0) begin
            first_state = ST_MARK;
        end else if (i_cmd.eot) begin
            first_state = ST_NL;
        end else begin
            first_state = ST_IDLE;
        end
    end

    assign tail_state = r_cmd.eot ? ST_NL : ST_IDLE;
    assign body_state = (r_cmd.nsym != 3'd0) ? ST_MARK : tail_state;

    // Next state
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = first_state;
                    n_idx   = '0;
                end
            end
            ST_WSP0: if (adv) n_state = ST_WSP1;
            ST_WSP1: if (adv) n_state = ST_WSP2;
            ST_WSP2: if (adv) n_state = r_cmd.letter_gap ? ST_LGAP : body_state;
            ST_LGAP: if (adv) n_state = ST_LSPC;
            ST_LSPC: if (adv) n_state = body_state;
            ST_MARK: if (adv) n_state = ST_SOFF;
            ST_SOFF: begin
                if (adv) begin
                    if (more_sym) begin
                        n_state = ST_MARK;
                        n_idx   = r_idx + 2'd1;
                    end else begin
                        n_state = tail_state;
                    end
                end
            end
            ST_NL:   if (adv) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Event produced by the current state
    always_comb begin
        emit = 1'b1;
        sym  = SYM_NONE;
        led  = 1'b0;
        hold = '0;
        unique case (r_state)
            ST_IDLE: emit = 1'b0;
            ST_WSP0, ST_WSP1: sym = SYM_SPACE;
            ST_WSP2: begin
                sym  = SYM_SPACE;
                hold = i_timing.word_gap;
            end
            ST_LGAP: hold = i_timing.letter_gap;
            ST_LSPC: sym = SYM_SPACE;
            ST_MARK: begin
                led = 1'b1;
                if (r_cmd.dash[r_idx]) begin
                    sym  = SYM_DASH;
                    hold = i_timing.dash;
                end else begin
                    sym  = SYM_DOT;
                    hold = i_timing.dot;
                end
            end
            ST_SOFF: hold = more_sym ? i_timing.dot : '0;
            ST_NL:   sym = SYM_NL;
            default: emit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            if (adv) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (adv && emit) begin
            r_sym  <= sym;
            r_led  <= led;
            r_hold <= hold;
            r_last <= (n_state == ST_IDLE);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_echo_symbol = r_sym;
    assign o_led_on      = r_led;
    assign o_hold_ms     = r_hold;
    assign o_last_result = r_last;

endmodule

// ===== rtl/morse_text_keyer_unit.sv =====
// Morse text keyer top level: APB timing registers, front end, command queue
// and keying sequencer. Depends on mtk_pkg, mtk_front, mtk_cmd_fifo, mtk_back.
//
// Text bytes come in on the input channel, one transaction per byte; each
// result transaction is one keying event (echo mark, LED level, hold time in
// ms). A letter gives at most 12 events, space or other bytes give none
// (a space only marks a word boundary), and end_of_text adds a newline event
// and restarts the message spacing. The front end classifies a byte in the
// cycle it is accepted and queues a command in a 2-entry queue, so bytes keep
// being accepted while events are still draining. The sequencer picks up a
// command in its idle state and then issues one event per cycle when the
// output slot is free. Timing registers sit at byte addresses 0 (dot_ms),
// 4 (dash_ms), 8 (letter_gap_ms) and 12 (word_gap_ms), 14 bits each; write
// them only while no transaction is in flight.
`include "assert_macros.svh"

module morse_text_keyer_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // text input
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [7:0]                 i_char_code,
    input  logic                       i_end_of_text,
    // keying events
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [2:0]                 o_echo_symbol,
    output logic                       o_led_on,
    output logic [mtk_pkg::HOLD_W-1:0] o_hold_ms,
    output logic                       o_last_result,
    // APB configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [3:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import mtk_pkg::*;

    t_timing  r_timing;
    t_reg_idx reg_sel;
    logic     cfg_wr;

    logic     fifo_full;
    logic     fifo_empty;
    logic     push;
    logic     pop;
    t_cmd     push_cmd;
    t_cmd     head_cmd;
    t_sym     echo_sym;

    // ---------------- configuration registers ----------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timing.dot        <= HOLD_W'(200);
            r_timing.dash       <= HOLD_W'(600);
            r_timing.letter_gap <= HOLD_W'(600);
            r_timing.word_gap   <= HOLD_W'(1400);
        end else if (cfg_wr) begin
            unique case (reg_sel)
                REG_DOT:        r_timing.dot        <= pwdata[HOLD_W-1:0];
                REG_DASH:       r_timing.dash       <= pwdata[HOLD_W-1:0];
                REG_LETTER_GAP: r_timing.letter_gap <= pwdata[HOLD_W-1:0];
                REG_WORD_GAP:   r_timing.word_gap   <= pwdata[HOLD_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DOT:        prdata = 32'(r_timing.dot);
            REG_DASH:       prdata = 32'(r_timing.dash);
            REG_LETTER_GAP: prdata = 32'(r_timing.letter_gap);
            REG_WORD_GAP:   prdata = 32'(r_timing.word_gap);
            default:        prdata = '0;
        endcase
    end

    // ---------------- front end: classify and queue ----------------
    assign o_in_ready = !fifo_full;

    mtk_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_room        (!fifo_full),
        .i_char_code   (i_char_code),
        .i_end_of_text (i_end_of_text),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    mtk_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_full  (fifo_full),
        .o_empty (fifo_empty)
    );

    // ---------------- back end: event sequencer ----------------
    mtk_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (fifo_empty),
        .i_cmd         (head_cmd),
        .o_pop         (pop),
        .i_timing      (r_timing),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_echo_symbol (echo_sym),
        .o_led_on      (o_led_on),
        .o_hold_ms     (o_hold_ms),
        .o_last_result (o_last_result)
    );

    assign o_echo_symbol = echo_sym;

    // ---------------- checks ----------------
    // newline always closes the events of its byte
    `ASSERT_CLK(a_nl_is_last, (o_out_valid && echo_sym == SYM_NL) |-> o_last_result, "newline not last")
    // LED only lights for a dot or a dash
    `ASSERT_NEVER(a_led_mark, o_out_valid && o_led_on && echo_sym != SYM_DOT && echo_sym != SYM_DASH, "LED on without mark")
    // dot events carry the programmed dot time
    `ASSERT_CLK(a_dot_hold, (o_out_valid && echo_sym == SYM_DOT) |-> (o_hold_ms == r_timing.dot), "dot hold mismatch")

endmodule

// ===== sim/morse_text_keyer_unit_tb.sv =====
// Self-checking testbench for morse_text_keyer_unit: text bytes in, keying events out,
// checked against an in-bench prediction of the keying sequence.
// Depends on mtk_pkg (symbol, class and register enums, HOLD_W, CODE_BITS) and the RTL.
module morse_text_keyer_unit_tb;
    import mtk_pkg::*;

    typedef struct packed {
        logic [7:0] code;
        logic       eot;
    } t_text_byte;

    typedef struct {
        t_sym              sym;
        logic              led;
        logic [HOLD_W-1:0] hold;
        logic              last;
    } t_key_event;

    // On/off glyph patterns, A..Z, walked MSB first.
    localparam logic [15:0] GLYPH_BITS [26] = '{
        16'hB800, 16'hEA80, 16'hEBA0, 16'hEA00, 16'h8000, 16'hAE80, 16'hEE80,
        16'hAA00, 16'hA000, 16'hBBB8, 16'hEB80, 16'hBA80, 16'hEE00, 16'hE800,
        16'hEEE0, 16'hBBA0, 16'hEEB8, 16'hBA00, 16'hA800, 16'hE000, 16'hAE00,
        16'hAB80, 16'hBB80, 16'hEAE0, 16'hEBB8, 16'hEEA0
    };
    localparam int MAX_EVENTS = 12;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        in_valid      = 1'b0;
    logic [7:0]  char_code     = 8'h00;
    logic        end_of_text   = 1'b0;
    logic        out_ready     = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [3:0]  paddr         = 4'h0;
    logic [31:0] pwdata        = 32'h0;

    logic              o_in_ready;
    logic              o_out_valid;
    logic [2:0]        o_echo_symbol;
    logic              o_led_on;
    logic [HOLD_W-1:0] o_hold_ms;
    logic              o_last_result;
    logic [31:0]       prdata;
    logic              pready;

    morse_text_keyer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_char_code   (char_code),
        .i_end_of_text (end_of_text),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_echo_symbol (o_echo_symbol),
        .o_led_on      (o_led_on),
        .o_hold_ms     (o_hold_ms),
        .o_last_result (o_last_result),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #4 i_clk = ~i_clk;

    // Bytes waiting to be sent, and keying events still owed by the DUT.
    t_text_byte text_bytes [$];
    t_key_event keying_due [$];

    // Mirror of the timing registers and of the message spacing state.
    logic [HOLD_W-1:0] dot_len      = 14'd200;
    logic [HOLD_W-1:0] dash_len     = 14'd600;
    logic [HOLD_W-1:0] letter_pause = 14'd600;
    logic [HOLD_W-1:0] word_pause   = 14'd1400;
    t_cls              prev_class   = CLS_NONE;
    logic              first_word   = 1'b1;

    // Idle/stall knobs, changed per phase by the stimulus block.
    bit in_gaps_on  = 1'b1;
    bit out_stall_on = 1'b1;
    int in_gap_left  = 0;
    int out_stall_left = 0;

    int         fault_count = 0;
    t_key_event seen_ev;

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_event(ref t_key_event evs[$], input t_sym sym,
                                      input logic led, input logic [HOLD_W-1:0] hold);
        t_key_event ev;
        if (evs.size() >= MAX_EVENTS) return;
        ev.sym  = sym;
        ev.led  = led;
        ev.hold = hold;
        ev.last = 1'b0;
        evs.push_back(ev);
    endfunction

    // Expand one accepted byte into the keying events it should produce.
    function automatic void expand_char(input logic [7:0] ch, input logic eot);
        t_key_event evs [$];
        bit         is_dash [$];
        int         idx;
        int         run;
        idx = -1;
        if (ch >= 8'h41 && ch <= 8'h5A) idx = ch - 8'h41;
        else if (ch >= 8'h61 && ch <= 8'h7A) idx = ch - 8'h61;

        if (idx >= 0) begin
            // word gap only once the message has a letter in it
            if (first_word) begin
                first_word = 1'b0;
            end else if (prev_class == CLS_SPACE) begin
                add_event(evs, SYM_SPACE, 1'b0, '0);
                add_event(evs, SYM_SPACE, 1'b0, '0);
                add_event(evs, SYM_SPACE, 1'b0, word_pause);
            end
            if (prev_class == CLS_LETTER) begin
                add_event(evs, SYM_NONE, 1'b0, letter_pause);
                add_event(evs, SYM_SPACE, 1'b0, '0);
            end
            // runs of one or three 1s followed by a 0 are marks;
            // other run lengths keep counting
            run = 0;
            for (int i = 0; i < CODE_BITS; i++) begin
                if (GLYPH_BITS[idx][15-i]) begin
                    run++;
                end else if (run == 3) begin
                    is_dash.push_back(1'b1);
                    run = 0;
                end else if (run == 1) begin
                    is_dash.push_back(1'b0);
                    run = 0;
                end
            end
            foreach (is_dash[k]) begin
                add_event(evs, is_dash[k] ? SYM_DASH : SYM_DOT, 1'b1,
                          is_dash[k] ? dash_len : dot_len);
                add_event(evs, SYM_NONE, 1'b0, (k + 1 < is_dash.size()) ? dot_len : '0);
            end
            prev_class = CLS_LETTER;
        end else if (ch == ASCII_SPACE) begin
            prev_class = CLS_SPACE;
        end

        if (eot) begin
            add_event(evs, SYM_NL, 1'b0, '0);
            prev_class = CLS_NONE;
            first_word = 1'b1;
        end

        if (evs.size() > 0) evs[$].last = 1'b1;
        foreach (evs[k]) keying_due.push_back(evs[k]);
    endfunction

    task automatic log_fault(input string what);
        fault_count++;
        if (fault_count <= 10) $display("[%0t] %s", $realtime, what);
    endtask

    // Driver: one text byte per transaction, with random gaps between them while in_gaps_on is set.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_in_ready) expand_char(char_code, end_of_text);
            if (!in_valid || o_in_ready) begin
                if (in_gap_left > 0) begin
                    in_gap_left--;
                    in_valid <= 1'b0;
                end else if (text_bytes.size() > 0) begin
                    char_code   <= text_bytes[0].code;
                    end_of_text <= text_bytes[0].eot;
                    void'(text_bytes.pop_front());
                    in_valid    <= 1'b1;
                    in_gap_left = in_gaps_on ? pick_gap() : 0;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: takes keying events with random backpressure while out_stall_on is set, checks each one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (keying_due.size() == 0) begin
                    log_fault($sformatf("unexpected event sym=%0d led=%0d hold=%0d last=%0d",
                                        o_echo_symbol, o_led_on, o_hold_ms, o_last_result));
                end else begin
                    seen_ev = keying_due.pop_front();
                    if (o_echo_symbol !== seen_ev.sym || o_led_on !== seen_ev.led ||
                        o_hold_ms !== seen_ev.hold || o_last_result !== seen_ev.last) begin
                        log_fault($sformatf({"event mismatch exp sym=%0d led=%0d hold=%0d ",
                                             "last=%0d, got sym=%0d led=%0d hold=%0d last=%0d"},
                                            seen_ev.sym, seen_ev.led, seen_ev.hold,
                                            seen_ev.last, o_echo_symbol, o_led_on,
                                            o_hold_ms, o_last_result));
                    end
                end
            end
            if (out_stall_left == 0 && out_stall_on && $urandom_range(0, 3) == 0)
                out_stall_left = pick_gap();
            if (out_stall_left > 0) begin
                out_ready <= 1'b0;
                out_stall_left--;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic queue_byte(input logic [7:0] code, input logic eot);
        t_text_byte tb_byte;
        tb_byte.code = code;
        tb_byte.eot  = eot;
        text_bytes.push_back(tb_byte);
    endtask

    // Wait until the DUT has no transaction in flight; bytes that produce no
    // event may still be in the front end, hence the extra settling time.
    task automatic wait_idle();
        while (text_bytes.size() != 0 || in_valid || keying_due.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // APB write: setup then access; register takes the value on the access edge.
    task automatic reg_write(input t_reg_idx which, input logic [HOLD_W-1:0] val);
        logic [31:0] junk;
        junk = $urandom();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= {junk[31:HOLD_W], val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            REG_DOT:        dot_len      = val;
            REG_DASH:       dash_len     = val;
            REG_LETTER_GAP: letter_pause = val;
            REG_WORD_GAP:   word_pause   = val;
        endcase
    endtask

    task automatic set_timing(input logic [HOLD_W-1:0] dot, input logic [HOLD_W-1:0] dash,
                              input logic [HOLD_W-1:0] lgap, input logic [HOLD_W-1:0] wgap);
        reg_write(REG_DOT, dot);
        reg_write(REG_DASH, dash);
        reg_write(REG_LETTER_GAP, lgap);
        reg_write(REG_WORD_GAP, wgap);
    endtask

    function automatic logic [7:0] rand_letter();
        return 8'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? 8'h41 : 8'h61);
    endfunction

    // One message: words of random letters, some noise bytes, and usually an
    // end-of-text on the last letter. Some messages end on a space or a
    // noise byte, and some never end and run into the next one.
    task automatic queue_message(inout int counted);
        int words;
        int len;
        int ending;
        words  = $urandom_range(1, 4);
        ending = $urandom_range(0, 9);
        if ($urandom_range(0, 4) == 0) begin
            queue_byte(ASCII_SPACE, 1'b0);
            counted++;
        end
        for (int w = 0; w < words; w++) begin
            if (w > 0) begin
                repeat ($urandom_range(1, 2)) begin
                    queue_byte(ASCII_SPACE, 1'b0);
                    counted++;
                end
            end
            len = $urandom_range(1, 6);
            for (int l = 0; l < len; l++) begin
                if ($urandom_range(0, 9) == 0) queue_byte(8'($urandom_range(0, 255)), 1'b0);
                queue_byte(rand_letter(), (ending < 7) && (w == words - 1) && (l == len - 1));
                counted++;
            end
        end
        if (ending == 7) begin
            queue_byte(ASCII_SPACE, 1'b1);
            counted++;
        end else if (ending == 8) begin
            queue_byte(8'($urandom_range(0, 255)), 1'b1);
            counted++;
        end
    endtask

    task automatic run_text(input int target);
        int counted;
        counted = 0;
        while (counted < target) queue_message(counted);
        wait_idle();
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass at reset timing values.
        queue_byte("A", 1'b0);          // first letter: no gap
        queue_byte("z", 1'b0);          // letter after letter, lowercase
        queue_byte(ASCII_SPACE, 1'b0);
        queue_byte("Q", 1'b0);          // letter after space: word gap
        queue_byte(8'h00, 1'b0);        // ignored bytes, state must not move
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'hC9, 1'b0);        // Latin-1 letter, ignored
        queue_byte(8'h40, 1'b0);        // just outside the letter ranges
        queue_byte(8'h5B, 1'b0);
        queue_byte(8'h60, 1'b0);
        queue_byte(8'h7B, 1'b0);
        queue_byte("a", 1'b0);          // still a letter gap after the noise
        queue_byte("Z", 1'b1);          // end of text on a letter
        queue_byte(ASCII_SPACE, 1'b0);  // leading spaces: still first word
        queue_byte(ASCII_SPACE, 1'b0);
        queue_byte("E", 1'b0);
        queue_byte("J", 1'b0);
        queue_byte(ASCII_SPACE, 1'b1);  // end of text on a space
        queue_byte(8'h5B, 1'b1);        // end of text on an ignored byte
        queue_byte("I", 1'b1);          // one-letter message
        queue_byte("t", 1'b0);
        queue_byte(ASCII_SPACE, 1'b0);
        queue_byte("O", 1'b1);
        wait_idle();

        // Random text under several timing settings, extremes included.
        set_timing(14'($urandom_range(1, 16383)), 14'($urandom_range(1, 16383)),
                   14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
        run_text(50);

        in_gaps_on   = 1'b0;  // back-to-back stretch, no idling either side
        out_stall_on = 1'b0;
        set_timing(14'd1, 14'd1, 14'd0, 14'd0);
        run_text(50);

        in_gaps_on   = 1'b1;
        out_stall_on = 1'b1;
        set_timing(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
        run_text(50);

        set_timing(14'($urandom_range(1, 16383)), 14'($urandom_range(1, 16383)),
                   14'($urandom_range(0, 16383)), 14'($urandom_range(0, 16383)));
        run_text(50);

        repeat (30) @(posedge i_clk);
        if (keying_due.size() != 0)
            log_fault($sformatf("%0d keying events never arrived", keying_due.size()));
        if (fault_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: worst case is far below this even with every stall at its longest.
    initial begin
        #6000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
